FILE: hw/rtl/wrst_pkg.sv
// Shared types, codes and helpers for the weekly relay schedule table.
// Used by every module under hw/rtl but the FIFO; depends on nothing else.
package wrst_pkg;

	// Default sizes, handed down from the top level as parameters.
	localparam int MAX_ENTRIES_DEF = 8;
	localparam int NUM_RELAYS_DEF  = 8;

	// Events produced by one tick at most, and the width of that count.
	localparam int RESULT_LIMIT = 8;
	localparam int NEV_W        = $clog2(RESULT_LIMIT + 1);

	// Stored relay number, wide enough for the largest relay count.
	localparam int RELAY_W = 4;
	// Minutes since midnight for any 5-bit hour and 6-bit minute.
	localparam int MIN_W   = 11;

	// Operation codes as they arrive on the input.
	localparam logic [2:0] OP_TICK    = 3'd0;
	localparam logic [2:0] OP_ADD     = 3'd1;
	localparam logic [2:0] OP_REMOVE  = 3'd2;
	localparam logic [2:0] OP_ENABLE  = 3'd3;
	localparam logic [2:0] OP_DISABLE = 3'd4;
	localparam logic [2:0] OP_CLEAR   = 3'd5;

	// Status codes of a result.
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_FULL      = 2'd1;
	localparam logic [1:0] ST_BAD_FIELD = 2'd2;
	localparam logic [1:0] ST_BAD_INDEX = 2'd3;

	// Configuration register address.
	localparam logic [2:0] REG_CLOCK_VALID = 3'd0;

	// Command kinds after decoding in the front end.
	typedef enum logic [2:0] {
		CMD_TICK,
		CMD_ADD,
		CMD_REMOVE,
		CMD_ENABLE,
		CMD_DISABLE,
		CMD_CLEAR,
		CMD_BADOP
	} cmd_kind_t;

	// Back end sequencer states.
	typedef enum logic [1:0] {
		BK_IDLE,
		BK_SCAN,
		BK_FLUSH
	} back_state_t;

	// One decoded command, as it travels through the command queue.
	typedef struct packed {
		cmd_kind_t          kind;
		logic [RELAY_W-1:0] relay;
		logic [4:0]         on_hour;
		logic [5:0]         on_minute;
		logic [4:0]         off_hour;
		logic [5:0]         off_minute;
		logic [6:0]         day_mask;
		logic [3:0]         index;
		logic               fields_bad;
		logic [MIN_W-1:0]   now_min;
		logic [5:0]         now_minute;
		logic [6:0]         weekday_oh;
	} cmd_t;

	// One schedule entry.
	typedef struct packed {
		logic [RELAY_W-1:0] relay;
		logic [4:0]         on_hour;
		logic [5:0]         on_minute;
		logic [4:0]         off_hour;
		logic [5:0]         off_minute;
		logic [6:0]         day_mask;
		logic               en;
		logic               act;
	} entry_t;

	// One result item.
	typedef struct packed {
		logic       event_valid;
		logic [2:0] relay_id;
		logic       relay_on;
		logic [1:0] status;
		logic       last;
	} res_t;

	// Minutes since midnight: hour * 60 + minute, as hour*64 - hour*4.
	function automatic logic [MIN_W-1:0] minutes_of(input logic [4:0] hour,
		input logic [5:0] minute);
		logic [MIN_W-1:0] h;
		h = MIN_W'(hour);
		return (h << 6) - (h << 2) + MIN_W'(minute);
	endfunction

endpackage

FILE: hw/rtl/wrst_fifo.sv
// Small synchronous FIFO used for the command queue and the result queue.
// Depends on nothing but its parameters.
module wrst_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	// Pointer and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

FILE: hw/rtl/wrst_front.sv
// Front end: decodes an incoming item into a command and checks its fields.
// Depends on wrst_pkg.
module wrst_front
	import wrst_pkg::*;
#(
	parameter int NUM_RELAYS = NUM_RELAYS_DEF
) (
	input  logic [2:0] operation,
	input  logic [7:0] relay_number,
	input  logic [4:0] on_hour,
	input  logic [5:0] on_minute,
	input  logic [4:0] off_hour,
	input  logic [5:0] off_minute,
	input  logic [6:0] day_mask,
	input  logic [3:0] entry_index,
	input  logic [4:0] now_hour,
	input  logic [5:0] now_minute,
	input  logic [2:0] now_weekday,
	output cmd_t       cmd
);

	cmd_kind_t kind;

	// Operation decode; codes without meaning become a bad operation.
	always_comb begin
		unique case (operation)
			OP_TICK:    kind = CMD_TICK;
			OP_ADD:     kind = CMD_ADD;
			OP_REMOVE:  kind = CMD_REMOVE;
			OP_ENABLE:  kind = CMD_ENABLE;
			OP_DISABLE: kind = CMD_DISABLE;
			OP_CLEAR:   kind = CMD_CLEAR;
			default:    kind = CMD_BADOP;
		endcase
	end

	// Field checks for an add, the tick time in minutes and the weekday as a mask.
	always_comb begin
		cmd.kind       = kind;
		cmd.relay      = RELAY_W'(relay_number);
		cmd.on_hour    = on_hour;
		cmd.on_minute  = on_minute;
		cmd.off_hour   = off_hour;
		cmd.off_minute = off_minute;
		cmd.day_mask   = day_mask;
		cmd.index      = entry_index;
		cmd.fields_bad = (relay_number >= 8'(NUM_RELAYS)) ||
			(on_hour > 5'd23) || (off_hour > 5'd23) ||
			(on_minute > 6'd59) || (off_minute > 6'd59);
		cmd.now_min    = minutes_of(now_hour, now_minute);
		cmd.now_minute = now_minute;
		if (now_weekday == 3'd0) begin
			cmd.weekday_oh = '0;
		end else begin
			cmd.weekday_oh = 7'(7'd1 << 3'(now_weekday - 3'd1));
		end
	end

endmodule

FILE: hw/rtl/wrst_back.sv
// Back end: holds the schedule table and carries out decoded commands; on a
// tick it walks the table one entry per cycle unless stalled. Depends on wrst_pkg.
module wrst_back
	import wrst_pkg::*;
#(
	parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic clock_valid,
	input  cmd_t cmd,
	input  logic cmd_empty,
	output logic cmd_pop,
	output res_t res,
	output logic res_push,
	input  logic res_full
);

	localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

	back_state_t      state_q, state_d;
	entry_t           table_q [MAX_ENTRIES];
	logic [CNT_W-1:0] entry_count_q;
	logic [5:0]       last_seen_q;
	logic [CNT_W-1:0] scan_idx_q;
	logic [NEV_W-1:0] n_ev_q;
	logic             pend_v_q;
	res_t             pend_q;
	logic [MIN_W-1:0] tick_now_q;
	logic [6:0]       tick_wd_q;

	logic             take, tick_eval, idx_ok, room_ok, apply_cmd;
	logic [1:0]       cmd_status;
	entry_t           cur;
	logic [MIN_W-1:0] start_min, stop_min;
	logic             in_window, want, scan_live, change, scan_stall, scan_step;

	// A command is taken from the queue only when a result slot is free.
	assign take      = (state_q == BK_IDLE) && !cmd_empty && !res_full;
	assign tick_eval = (cmd.kind == CMD_TICK) && clock_valid &&
		(cmd.now_minute != last_seen_q);
	assign idx_ok    = ({1'b0, cmd.index} < 5'(entry_count_q));
	assign room_ok   = (entry_count_q < CNT_W'(MAX_ENTRIES));

	// Status of a one-result command.
	always_comb begin
		case (cmd.kind) inside
			CMD_ADD: begin
				if (!room_ok) begin
					cmd_status = ST_FULL;
				end else if (cmd.fields_bad) begin
					cmd_status = ST_BAD_FIELD;
				end else begin
					cmd_status = ST_OK;
				end
			end
			CMD_REMOVE, CMD_ENABLE, CMD_DISABLE: begin
				cmd_status = idx_ok ? ST_OK : ST_BAD_INDEX;
			end
			CMD_BADOP: cmd_status = ST_BAD_FIELD;
			default:   cmd_status = ST_OK;
		endcase
	end
	assign apply_cmd = take && (cmd_status == ST_OK);

	// Window check of the entry under the scan pointer; a window whose end
	// lies before its start crosses midnight.
	assign scan_live = (5'(scan_idx_q) < 5'(entry_count_q));
	assign cur       = table_q[scan_idx_q[IDX_W-1:0]];
	assign start_min = minutes_of(cur.on_hour, cur.on_minute);
	assign stop_min  = minutes_of(cur.off_hour, cur.off_minute);
	always_comb begin
		if (stop_min < start_min) begin
			in_window = (tick_now_q >= start_min) || (tick_now_q < stop_min);
		end else begin
			in_window = (tick_now_q >= start_min) && (tick_now_q < stop_min);
		end
	end
	assign want       = (|(cur.day_mask & tick_wd_q)) && in_window;
	assign change     = scan_live && cur.en && (want != cur.act) &&
		(n_ev_q < NEV_W'(RESULT_LIMIT));
	assign scan_stall = change && pend_v_q && res_full;
	assign scan_step  = (state_q == BK_SCAN) && scan_live && !scan_stall;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (take && tick_eval) begin
					state_d = BK_SCAN;
				end
			end
			BK_SCAN: begin
				if (!scan_live) begin
					state_d = BK_FLUSH;
				end
			end
			BK_FLUSH: begin
				if (!res_full) begin
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	// Outputs: queue pop and result pushes.
	always_comb begin
		cmd_pop  = 1'b0;
		res_push = 1'b0;
		res      = '{event_valid: 1'b0, relay_id: 3'd0, relay_on: 1'b0,
			status: ST_OK, last: 1'b1};
		unique case (state_q)
			BK_IDLE: begin
				cmd_pop = take;
				if (take && !tick_eval) begin
					res_push   = 1'b1;
					res.status = cmd_status;
				end
			end
			BK_SCAN: begin
				// A newer event pushes out the one held back.
				if (scan_step && change && pend_v_q) begin
					res_push = 1'b1;
					res      = pend_q;
				end
			end
			BK_FLUSH: begin
				if (!res_full) begin
					res_push = 1'b1;
					if (pend_v_q) begin
						res      = pend_q;
						res.last = 1'b1;
					end
				end
			end
			default: ;
		endcase
	end

	// Sequencer control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= BK_IDLE;
			entry_count_q <= '0;
			last_seen_q   <= '0;
			scan_idx_q    <= '0;
			n_ev_q        <= '0;
			pend_v_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			if (take && tick_eval) begin
				last_seen_q <= cmd.now_minute;
				scan_idx_q  <= '0;
				n_ev_q      <= '0;
				pend_v_q    <= 1'b0;
			end
			if (apply_cmd) begin
				case (cmd.kind)
					CMD_ADD:    entry_count_q <= entry_count_q + 1'b1;
					CMD_REMOVE: entry_count_q <= entry_count_q - 1'b1;
					CMD_CLEAR:  entry_count_q <= '0;
					default: ;
				endcase
			end
			if (scan_step) begin
				scan_idx_q <= scan_idx_q + 1'b1;
				if (change) begin
					n_ev_q   <= n_ev_q + 1'b1;
					pend_v_q <= 1'b1;
				end
			end
		end
	end

	// Tick time, held event and table contents.
	always_ff @(posedge clk) begin
		if (take && tick_eval) begin
			tick_now_q <= cmd.now_min;
			tick_wd_q  <= cmd.weekday_oh;
		end
		if (scan_step && change) begin
			pend_q <= '{event_valid: 1'b1, relay_id: 3'(cur.relay),
				relay_on: want, status: ST_OK, last: 1'b0};
			table_q[scan_idx_q[IDX_W-1:0]].act <= want;
		end
		if (apply_cmd) begin
			case (cmd.kind)
				CMD_ADD: begin
					table_q[entry_count_q[IDX_W-1:0]] <= '{relay: cmd.relay,
						on_hour: cmd.on_hour, on_minute: cmd.on_minute,
						off_hour: cmd.off_hour, off_minute: cmd.off_minute,
						day_mask: cmd.day_mask, en: 1'b1, act: 1'b0};
				end
				CMD_REMOVE: begin
					for (int i = 0; i < MAX_ENTRIES - 1; i++) begin
						if (5'(i) >= {1'b0, cmd.index}) begin
							table_q[i] <= table_q[i + 1];
						end
					end
				end
				CMD_ENABLE:  table_q[cmd.index[IDX_W-1:0]].en <= 1'b1;
				CMD_DISABLE: table_q[cmd.index[IDX_W-1:0]].en <= 1'b0;
				default: ;
			endcase
		end
	end

	// The fill count never passes the table size.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		entry_count_q <= CNT_W'(MAX_ENTRIES))
		else $error("entry count above table size");

	// A tick never produces more events than the limit.
	a_event_limit: assert property (@(posedge clk) disable iff (!arst_n)
		n_ev_q <= NEV_W'(RESULT_LIMIT))
		else $error("too many events for one tick");

	// No result is pushed into a full result queue.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full)
		else $error("result pushed while queue full");

	// The scan pointer advances one entry at a time.
	a_scan_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_SCAN && scan_step) |=>
			(scan_idx_q == $past(scan_idx_q) + 1'b1))
		else $error("scan pointer skipped an entry");

	// The last result of a tick comes only from the flush state or idle.
	a_flush_last: assert property (@(posedge clk) disable iff (!arst_n)
		(res_push && state_q == BK_SCAN) |-> !res.last)
		else $error("last flag set in the middle of a scan");

endmodule

FILE: hw/rtl/weekly_relay_schedule_table.sv
// Top level of the weekly relay schedule table: configuration port, front end,
// command queue, back end and result queue. Depends on wrst_pkg and wrst_*.
//
// Channel   Handshake          Payload
// input     push / full        operation, relay_number, window, day_mask, index, time
// result    empty / pop        event_valid, relay_id, relay_on, status, last
// config    psel/penable/APB   paddr, pwdata, prdata (clock_valid at address 0)
//
// A non-tick item, or a tick that evaluates nothing, is done in the idle state.
// A tick that evaluates starts in idle, walks the table entry by entry with the
// single window comparator, closes the walk and then flushes; a full result
// queue can stall the walk.
// Two-entry queues on both sides let the front accept and results wait.
// Reset clears the entry count, the last minute, clock_valid and both queues.
// A full result queue stalls the back end; a full command queue raises full.
module weekly_relay_schedule_table
	import wrst_pkg::*;
#(
	parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
	parameter int NUM_RELAYS  = NUM_RELAYS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// Input item channel.
	input  logic        push,
	output logic        full,
	input  logic [2:0]  operation,
	input  logic [7:0]  relay_number,
	input  logic [4:0]  on_hour,
	input  logic [5:0]  on_minute,
	input  logic [4:0]  off_hour,
	input  logic [5:0]  off_minute,
	input  logic [6:0]  day_mask,
	input  logic [3:0]  entry_index,
	input  logic [4:0]  now_hour,
	input  logic [5:0]  now_minute,
	input  logic [2:0]  now_weekday,
	// Result channel.
	output logic        empty,
	input  logic        pop,
	output logic        event_valid,
	output logic [2:0]  relay_id,
	output logic        relay_on,
	output logic [1:0]  status,
	output logic        last,
	// Configuration port.
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int CMD_W = $bits(cmd_t);
	localparam int RES_W = $bits(res_t);

	logic             clock_valid_q;
	cmd_t             cmd_in, cmd_out;
	logic [CMD_W-1:0] cmd_rdata;
	logic             cmd_empty, cmd_pop;
	res_t             res_in, res_out;
	logic [RES_W-1:0] res_rdata;
	logic             res_push, res_full;

	// Configuration register.
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_valid_q <= 1'b0;
		end else if (psel && penable && pwrite && pready &&
			(paddr == REG_CLOCK_VALID)) begin
			clock_valid_q <= pwdata[0];
		end
	end
	assign prdata = (paddr == REG_CLOCK_VALID) ? {31'd0, clock_valid_q} : 32'd0;

	// Front end decode.
	wrst_front #(
		.NUM_RELAYS(NUM_RELAYS)
	) u_front (
		.operation   (operation),
		.relay_number(relay_number),
		.on_hour     (on_hour),
		.on_minute   (on_minute),
		.off_hour    (off_hour),
		.off_minute  (off_minute),
		.day_mask    (day_mask),
		.entry_index (entry_index),
		.now_hour    (now_hour),
		.now_minute  (now_minute),
		.now_weekday (now_weekday),
		.cmd         (cmd_in)
	);

	// Command queue between front and back.
	wrst_fifo #(
		.WIDTH(CMD_W),
		.DEPTH(2)
	) u_cmd_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wdata (cmd_in),
		.full  (full),
		.pop   (cmd_pop),
		.rdata (cmd_rdata),
		.empty (cmd_empty)
	);
	assign cmd_out = cmd_t'(cmd_rdata);

	// Back end execution.
	wrst_back #(
		.MAX_ENTRIES(MAX_ENTRIES)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.clock_valid(clock_valid_q),
		.cmd        (cmd_out),
		.cmd_empty  (cmd_empty),
		.cmd_pop    (cmd_pop),
		.res        (res_in),
		.res_push   (res_push),
		.res_full   (res_full)
	);

	// Result queue toward the consumer.
	wrst_fifo #(
		.WIDTH(RES_W),
		.DEPTH(2)
	) u_res_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (res_push),
		.wdata (res_in),
		.full  (res_full),
		.pop   (pop),
		.rdata (res_rdata),
		.empty (empty)
	);
	assign res_out     = res_t'(res_rdata);
	assign event_valid = res_out.event_valid;
	assign relay_id    = res_out.relay_id;
	assign relay_on    = res_out.relay_on;
	assign status      = res_out.status;
	assign last        = res_out.last;

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for weekly_relay_schedule_table: directed and random items
// are checked against a behavioral schedule model held in the testbench.
// Depends on wrst_pkg and the RTL of the block.
module testbench;
	import wrst_pkg::*;

	// Bounds of a valid window time.
	localparam int LAST_HOUR      = 23;
	localparam int LAST_MINUTE    = 59;
	localparam int MIN_PER_HOUR   = 60;
	// Operation codes the block does not define.
	localparam logic [2:0] OP_SPARE_6 = 3'd6;
	localparam logic [2:0] OP_SPARE_7 = 3'd7;
	// Quiet cycles allowed after the last result, and the run limit.
	localparam int SETTLE_CYCLES  = 24;
	localparam int RUN_LIMIT      = 2_000_000;
	localparam int GAP_PERCENT    = 37;

	// One input item, field by field.
	typedef struct {
		logic [2:0] op;
		logic [7:0] relay;
		logic [4:0] on_h;
		logic [5:0] on_m;
		logic [4:0] off_h;
		logic [5:0] off_m;
		logic [6:0] days;
		logic [3:0] idx;
		logic [4:0] now_h;
		logic [5:0] now_m;
		logic [2:0] now_wd;
	} sched_cmd_t;

	// One entry of the schedule model.
	typedef struct {
		logic [2:0] relay;
		logic [4:0] on_h;
		logic [5:0] on_m;
		logic [4:0] off_h;
		logic [5:0] off_m;
		logic [6:0] days;
		bit         en;
		bit         act;
	} window_rec_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        full;
	logic [2:0]  operation = OP_CLEAR;
	logic [7:0]  relay_number = '0;
	logic [4:0]  on_hour = '0;
	logic [5:0]  on_minute = '0;
	logic [4:0]  off_hour = '0;
	logic [5:0]  off_minute = '0;
	logic [6:0]  day_mask = '0;
	logic [3:0]  entry_index = '0;
	logic [4:0]  now_hour = '0;
	logic [5:0]  now_minute = '0;
	logic [2:0]  now_weekday = '0;
	logic        empty;
	logic        pop = 1'b0;
	logic        event_valid;
	logic [2:0]  relay_id;
	logic        relay_on;
	logic [1:0]  status;
	logic        last;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	// Schedule model and the results it still expects.
	window_rec_t sched_model[MAX_ENTRIES_DEF];
	int          entry_total = 0;
	logic [5:0]  last_minute_model = '0;
	bit          clock_valid_model = 1'b0;
	res_t        pending_results[$];
	int          errors = 0;
	bit          quiet_stretch = 1'b0;

	weekly_relay_schedule_table dut (
		.clk(clk), .arst_n(arst_n),
		.push(push), .full(full),
		.operation(operation), .relay_number(relay_number),
		.on_hour(on_hour), .on_minute(on_minute),
		.off_hour(off_hour), .off_minute(off_minute),
		.day_mask(day_mask), .entry_index(entry_index),
		.now_hour(now_hour), .now_minute(now_minute), .now_weekday(now_weekday),
		.empty(empty), .pop(pop),
		.event_valid(event_valid), .relay_id(relay_id), .relay_on(relay_on),
		.status(status), .last(last),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Random idle decision shared by both sides.
	function automatic bit take_gap();
		return !quiet_stretch && ($urandom_range(99) < GAP_PERCENT);
	endfunction

	// Whether an entry's window and day mask cover the given time.
	function automatic bit window_hit(window_rec_t w, logic [4:0] hr, logic [5:0] mn,
		logic [2:0] wd);
		int now_m, start_m, stop_m;
		if (wd == 3'd0)
			return 1'b0;
		if (!w.days[wd - 3'd1])
			return 1'b0;
		now_m   = int'(hr) * MIN_PER_HOUR + int'(mn);
		start_m = int'(w.on_h) * MIN_PER_HOUR + int'(w.on_m);
		stop_m  = int'(w.off_h) * MIN_PER_HOUR + int'(w.off_m);
		// An end before the start means the window runs past midnight.
		if (stop_m < start_m)
			return now_m >= start_m || now_m < stop_m;
		return now_m >= start_m && now_m < stop_m;
	endfunction

	function automatic res_t make_result(logic ev, logic [2:0] rid, logic on,
		logic [1:0] st, logic lst);
		res_t r;
		r.event_valid = ev;
		r.relay_id    = rid;
		r.relay_on    = on;
		r.status      = st;
		r.last        = lst;
		return r;
	endfunction

	// Apply one accepted item to the model and queue the results it causes.
	task automatic predict_switch_events(input sched_cmd_t c);
		res_t        batch[RESULT_LIMIT];
		int          n;
		int          i;
		logic [1:0]  st;
		bit          want;
		window_rec_t w;
		n  = 0;
		st = ST_OK;
		case (c.op)
			OP_TICK: begin
				if (clock_valid_model && c.now_m != last_minute_model) begin
					last_minute_model = c.now_m;
					for (i = 0; i < entry_total; i++) begin
						if (sched_model[i].en) begin
							want = window_hit(sched_model[i], c.now_h, c.now_m, c.now_wd);
							// Changes beyond the event limit wait for a later tick.
							if (want != sched_model[i].act && n < RESULT_LIMIT) begin
								sched_model[i].act = want;
								batch[n] = make_result(1'b1, sched_model[i].relay, want,
									ST_OK, 1'b0);
								n++;
							end
						end
					end
				end
			end
			OP_ADD: begin
				if (entry_total >= MAX_ENTRIES_DEF) begin
					st = ST_FULL;
				end else if (c.relay >= NUM_RELAYS_DEF || c.on_h > LAST_HOUR ||
					c.off_h > LAST_HOUR || c.on_m > LAST_MINUTE ||
					c.off_m > LAST_MINUTE) begin
					st = ST_BAD_FIELD;
				end else begin
					w.relay = c.relay[2:0];
					w.on_h  = c.on_h;
					w.on_m  = c.on_m;
					w.off_h = c.off_h;
					w.off_m = c.off_m;
					w.days  = c.days;
					w.en    = 1'b1;
					w.act   = 1'b0;
					sched_model[entry_total] = w;
					entry_total++;
				end
			end
			OP_REMOVE: begin
				if (c.idx >= entry_total) begin
					st = ST_BAD_INDEX;
				end else begin
					for (i = int'(c.idx); i + 1 < entry_total; i++)
						sched_model[i] = sched_model[i + 1];
					entry_total--;
				end
			end
			OP_ENABLE, OP_DISABLE: begin
				if (c.idx >= entry_total)
					st = ST_BAD_INDEX;
				else
					sched_model[c.idx].en = (c.op == OP_ENABLE);
			end
			OP_CLEAR: begin
				entry_total = 0;
			end
			default: begin
				st = ST_BAD_FIELD;
			end
		endcase
		// With no events the item yields a single status result.
		if (n == 0) begin
			batch[0] = make_result(1'b0, 3'd0, 1'b0, st, 1'b1);
			n = 1;
		end else begin
			batch[n - 1].last = 1'b1;
		end
		for (i = 0; i < n; i++)
			pending_results.push_back(batch[i]);
	endtask

	// Item builders; fields the operation ignores stay random.
	function automatic sched_cmd_t raw_item();
		sched_cmd_t c;
		c.op     = 3'($urandom);
		c.relay  = 8'($urandom);
		c.on_h   = 5'($urandom);
		c.on_m   = 6'($urandom);
		c.off_h  = 5'($urandom);
		c.off_m  = 6'($urandom);
		c.days   = 7'($urandom);
		c.idx    = 4'($urandom);
		c.now_h  = 5'($urandom);
		c.now_m  = 6'($urandom);
		c.now_wd = 3'($urandom);
		return c;
	endfunction

	function automatic sched_cmd_t add_item(logic [7:0] relay, logic [4:0] onh,
		logic [5:0] onm, logic [4:0] offh, logic [5:0] offm, logic [6:0] days);
		sched_cmd_t c;
		c       = raw_item();
		c.op    = OP_ADD;
		c.relay = relay;
		c.on_h  = onh;
		c.on_m  = onm;
		c.off_h = offh;
		c.off_m = offm;
		c.days  = days;
		return c;
	endfunction

	function automatic sched_cmd_t valid_add_item();
		return add_item(8'($urandom_range(NUM_RELAYS_DEF - 1)),
			5'($urandom_range(LAST_HOUR)), 6'($urandom_range(LAST_MINUTE)),
			5'($urandom_range(LAST_HOUR)), 6'($urandom_range(LAST_MINUTE)),
			($urandom_range(3) == 0) ? 7'h7F : 7'($urandom));
	endfunction

	function automatic sched_cmd_t tick_item(logic [4:0] hr, logic [5:0] mn,
		logic [2:0] wd);
		sched_cmd_t c;
		c        = raw_item();
		c.op     = OP_TICK;
		c.now_h  = hr;
		c.now_m  = mn;
		c.now_wd = wd;
		return c;
	endfunction

	function automatic sched_cmd_t index_item(logic [2:0] op, logic [3:0] idx);
		sched_cmd_t c;
		c     = raw_item();
		c.op  = op;
		c.idx = idx;
		return c;
	endfunction

	// Mostly well-formed traffic, with some noise and broken items.
	function automatic sched_cmd_t random_item();
		sched_cmd_t c;
		int         roll;
		logic [3:0] pick;
		roll = $urandom_range(99);
		pick = (entry_total > 0 && $urandom_range(7) != 0) ?
			4'($urandom_range(entry_total - 1)) : 4'($urandom);
		if (roll < 28) begin
			// Keep the table churning once it is full.
			if (entry_total >= MAX_ENTRIES_DEF && $urandom_range(2) != 0)
				c = index_item(OP_REMOVE, pick);
			else if ($urandom_range(9) != 0)
				c = valid_add_item();
			else
				c = index_item(OP_ADD, pick);
		end else if (roll < 62) begin
			if ($urandom_range(9) == 0) begin
				c = index_item(OP_TICK, pick);
			end else begin
				c = tick_item(5'($urandom_range(LAST_HOUR)), 6'($urandom_range(LAST_MINUTE)),
					3'($urandom_range(7, 1)));
				if ($urandom_range(9) == 0)
					c.now_m = last_minute_model;
			end
		end else if (roll < 74) begin
			c = index_item($urandom_range(1) ? OP_ENABLE : OP_DISABLE, pick);
		end else if (roll < 86) begin
			c = index_item(OP_REMOVE, pick);
		end else if (roll < 90) begin
			c = index_item(OP_CLEAR, pick);
		end else begin
			c = raw_item();
		end
		return c;
	endfunction

	// Offer one item and wait until the block takes it.
	task automatic send_item(input sched_cmd_t c);
		@(negedge clk);
		while (take_gap()) begin
			push <= 1'b0;
			@(negedge clk);
		end
		operation    <= c.op;
		relay_number <= c.relay;
		on_hour      <= c.on_h;
		on_minute    <= c.on_m;
		off_hour     <= c.off_h;
		off_minute   <= c.off_m;
		day_mask     <= c.days;
		entry_index  <= c.idx;
		now_hour     <= c.now_h;
		now_minute   <= c.now_m;
		now_weekday  <= c.now_wd;
		push         <= 1'b1;
		@(posedge clk);
		while (full)
			@(posedge clk);
		predict_switch_events(c);
	endtask

	// Stop offering items and let every expected result drain out.
	task automatic drain_results();
		@(negedge clk);
		push <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apb_access(input bit wr, input logic [31:0] data,
		output logic [31:0] rd);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= REG_CLOCK_VALID;
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		rd = prdata;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic read_back_clock_valid();
		logic [31:0] rd;
		apb_access(1'b0, 32'd0, rd);
		if (rd !== 32'(clock_valid_model)) begin
			$error("clock_valid: expected %0d, got %0d", clock_valid_model, rd);
			errors++;
		end
	endtask

	// Registers change only with the block drained.
	task automatic set_clock_valid(input bit v);
		logic [31:0] rd;
		drain_results();
		apb_access(1'b1, 32'(v), rd);
		clock_valid_model = v;
		read_back_clock_valid();
	endtask

	// Ticks evaluate nothing until the time source is marked present.
	task automatic test_clock_gate();
		read_back_clock_valid();
		send_item(add_item(8'd2, 5'd0, 6'd0, 5'd23, 6'd59, 7'h7F));
		send_item(tick_item(5'd10, 6'd5, 3'd2));
		set_clock_valid(1'b1);
		send_item(tick_item(5'd10, 6'd5, 3'd2));
		send_item(index_item(OP_CLEAR, 4'd0));
	endtask

	// Error codes, window edge cases, enable and disable, full table.
	task automatic test_directed_ops();
		int k;
		send_item(index_item(OP_REMOVE, 4'd0));
		send_item(index_item(OP_ENABLE, 4'd15));
		send_item(index_item(OP_SPARE_6, 4'd0));
		send_item(index_item(OP_SPARE_7, 4'd0));
		send_item(add_item(8'd8, 5'd1, 6'd0, 5'd2, 6'd0, 7'h7F));
		send_item(add_item(8'd1, 5'd24, 6'd60, 5'd2, 6'd0, 7'h7F));
		send_item(add_item(8'd255, 5'd1, 6'd0, 5'd31, 6'd63, 7'h7F));
		// Daytime window, one across midnight on Monday, and a zero day mask.
		send_item(add_item(8'd0, 5'd8, 6'd0, 5'd9, 6'd0, 7'h7F));
		send_item(add_item(8'd7, 5'd22, 6'd0, 5'd2, 6'd0, 7'h01));
		send_item(add_item(8'd3, 5'd0, 6'd0, 5'd23, 6'd59, 7'h00));
		// Same minute as the last tick: nothing is evaluated.
		send_item(tick_item(5'd8, 6'd5, 3'd1));
		send_item(tick_item(5'd8, 6'd30, 3'd1));
		// A disabled entry keeps its relay state.
		send_item(index_item(OP_DISABLE, 4'd0));
		send_item(tick_item(5'd23, 6'd15, 3'd1));
		send_item(index_item(OP_ENABLE, 4'd0));
		// Weekday zero turns every enabled entry off.
		send_item(tick_item(5'd23, 6'd20, 3'd0));
		// Hour and minute beyond their ranges.
		send_item(tick_item(5'd31, 6'd63, 3'd1));
		send_item(index_item(OP_REMOVE, 4'd0));
		for (k = 0; k < MAX_ENTRIES_DEF - 2; k++)
			send_item(valid_add_item());
		// A full table is reported ahead of bad fields.
		send_item(add_item(8'd255, 5'd31, 6'd63, 5'd31, 6'd63, 7'h7F));
		send_item(index_item(OP_CLEAR, 4'd0));
	endtask

	task automatic test_random_traffic(input bit valid_clock, input int count,
		input int quiet_count);
		int k;
		set_clock_valid(valid_clock);
		for (k = 0; k < count; k++) begin
			quiet_stretch = (k < quiet_count);
			send_item(random_item());
		end
		quiet_stretch = 1'b0;
	endtask

	// Result side: random stalls.
	always @(negedge clk) begin
		pop <= arst_n && !take_gap();
	end

	function automatic void check_field(string name, int want, int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endfunction

	// Compare each accepted result with the oldest expectation.
	always @(posedge clk) begin : result_check
		res_t want_res;
		if (arst_n && pop && !empty) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result: event_valid %0d relay_id %0d status %0d",
					event_valid, relay_id, status);
				errors++;
			end else begin
				want_res = pending_results.pop_front();
				check_field("event_valid", want_res.event_valid, event_valid);
				check_field("relay_id", want_res.relay_id, relay_id);
				check_field("relay_on", want_res.relay_on, relay_on);
				check_field("status", want_res.status, status);
				check_field("last", want_res.last, last);
			end
		end
	end

	initial begin
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		test_clock_gate();
		test_directed_ops();
		test_random_traffic(1'b1, 200, 60);
		test_random_traffic(1'b0, 40, 0);
		test_random_traffic(1'b1, 110, 0);
		drain_results();
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	// Hard limit on the whole run.
	initial begin
		#RUN_LIMIT;
		$display("FAILURE");
		$finish;
	end

endmodule
